/* rtl/msws_pkg.sv */
`timescale 1ns / 1ps

package msws_pkg;

	// Item operations
	localparam logic [1:0] OP_RGB     = 2'd0;
	localparam logic [1:0] OP_CODE    = 2'd1;
	localparam logic [1:0] OP_REFRESH = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	// Line phases of the serializer
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_HIGH  = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;
	localparam logic [1:0] PH_LATCH = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_ONE_HIGH  = 3'd0;
	localparam logic [2:0] REG_ONE_LOW   = 3'd1;
	localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
	localparam logic [2:0] REG_ZERO_LOW  = 3'd3;
	localparam logic [2:0] REG_LATCH_GAP = 3'd4;
	localparam logic [2:0] REG_INTENSITY = 3'd5;

	// Register reset values
	localparam logic [11:0] RST_ONE_HIGH  = 12'd14;
	localparam logic [11:0] RST_ONE_LOW   = 12'd12;
	localparam logic [11:0] RST_ZERO_HIGH = 12'd7;
	localparam logic [11:0] RST_ZERO_LOW  = 12'd16;
	localparam logic [15:0] RST_LATCH_GAP = 16'd1600;
	localparam logic [6:0]  RST_INTENSITY = 7'd10;

	// Color letters
	localparam logic [7:0] CODE_V = 8'h76;
	localparam logic [7:0] CODE_R = 8'h72;
	localparam logic [7:0] CODE_L = 8'h6C;
	localparam logic [7:0] CODE_J = 8'h6A;
	localparam logic [7:0] CODE_M = 8'h6D;
	localparam logic [7:0] CODE_T = 8'h74;
	localparam logic [7:0] CODE_O = 8'h6F;
	localparam logic [7:0] CODE_B = 8'h62;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} color_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic clear;
		logic load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fetch;
	} sts_t;

	// Map a color letter to levels scaled by the base brightness
	function automatic color_t code_color(input logic [7:0] code, input logic [6:0] lvl);
		color_t     c;
		logic [9:0] five;
		c = '0;
		five = 10'(lvl) * 10'd5;
		case (code)
			CODE_V: c.g = {1'b0, lvl};
			CODE_R: c.r = {1'b0, lvl};
			CODE_L: c.b = {1'b0, lvl};
			CODE_J: begin
				c.r = {1'b0, lvl};
				c.g = {1'b0, lvl};
			end
			CODE_M: begin
				c.r = {1'b0, lvl};
				c.b = {1'b0, lvl};
			end
			CODE_T: begin
				c.g = {lvl, 1'b0};
				c.b = {1'b0, lvl};
			end
			CODE_O: begin
				c.r = five[9] ? 8'hFF : five[8:1];
				c.g = {2'b00, lvl[6:1]};
			end
			CODE_B: begin
				c.r = {1'b0, lvl};
				c.g = {1'b0, lvl};
				c.b = {1'b0, lvl};
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

/* rtl/msws_item_if.sv */
`timescale 1ns / 1ps

interface msws_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [2:0] strip;
	logic [5:0] led_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] color_code;

	modport source (
		output valid, operation, strip, led_index, red, green, blue, color_code,
		input  ready
	);
	modport sink (
		input  valid, operation, strip, led_index, red, green, blue, color_code,
		output ready
	);
endinterface

/* rtl/msws_result_if.sv */
`timescale 1ns / 1ps

interface msws_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] pin_levels;
	logic       busy_res;
	logic       accepted;

	modport source (
		output valid, pin_levels, busy_res, accepted,
		input  ready
	);
	modport sink (
		input  valid, pin_levels, busy_res, accepted,
		output ready
	);
endinterface

/* rtl/msws_cfg_if.sv */
`timescale 1ns / 1ps

interface msws_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  reg_index;
	logic [15:0] data;

	modport source (
		output valid, reg_index, data,
		input  ready
	);
	modport sink (
		input  valid, reg_index, data,
		output ready
	);
endinterface

/* rtl/multi_strip_ws2812_serializer_core.sv */
`timescale 1ns / 1ps
// Channel   Modport  Beat
// item      sink     operation, strip, led_index, red, green, blue, color_code
// result    source   pin_levels, busy_res, accepted (one beat per item)
// cfg       sink     reg_index, data (register write, always ready)
//
// Writes, ticks inside a byte and idle items keep the controller in its run state.
// A taken refresh, and a tick that moves on to the next byte, pass through a fetch state:
// the frame store read is registered and the bit count loads from it.
// After reset the frame store is cleared one pair row a cycle, all STRIPS *
// ceil(LEDS_PER_STRIP / 2) rows, with item.ready low; cfg writes are taken.
// The next item is taken while a result beat is handed off; a stalled result
// holds item.ready low.

module multi_strip_ws2812_serializer_core #(
	parameter int STRIPS         = 8,
	parameter int LEDS_PER_STRIP = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	msws_item_if.sink    item,
	msws_result_if.source result,
	msws_cfg_if.sink     cfg
);

	localparam int PAIRS = (LEDS_PER_STRIP + 1) / 2;
	localparam int ROWS  = STRIPS * PAIRS;
	localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	msws_pkg::cmd_t cmd;
	msws_pkg::sts_t sts;
	logic [RAW-1:0] clear_row;

	assign cfg.ready = 1'b1;

	msws_ctrl #(
		.ROWS(ROWS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd),
		.clear_row (clear_row)
	);

	msws_dp #(
		.STRIPS         (STRIPS),
		.LEDS_PER_STRIP (LEDS_PER_STRIP)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.clear_row  (clear_row),
		.operation  (item.operation),
		.strip      (item.strip),
		.led_index  (item.led_index),
		.red        (item.red),
		.green      (item.green),
		.blue       (item.blue),
		.color_code (item.color_code),
		.cfg_we     (cfg.valid),
		.cfg_index  (cfg.reg_index),
		.cfg_data   (cfg.data),
		.pin_levels (result.pin_levels),
		.busy_res   (result.busy_res),
		.accepted   (result.accepted)
	);

endmodule

/* rtl/msws_ctrl.sv */
`timescale 1ns / 1ps

module msws_ctrl #(
	parameter int ROWS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  msws_pkg::sts_t       sts,
	output msws_pkg::cmd_t       cmd,
	output logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] clear_row
);

	localparam int RAW = (ROWS > 1) ? $clog2(ROWS) : 1;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_FETCH = 2'd2;

	logic [1:0]     state_q;
	logic [1:0]     state_d;
	logic [RAW-1:0] clr_q;
	logic           out_valid_q;
	logic           take;

	// Take an item only while running and the result register is free or draining
	assign in_ready  = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign take      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign clear_row = clr_q;

	assign cmd.take  = take;
	assign cmd.clear = (state_q == ST_CLEAR);
	assign cmd.load  = (state_q == ST_FETCH);

	// Sequence clear sweep, item handling and byte fetch
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == RAW'(ROWS - 1)) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (take && sts.fetch) state_d = ST_FETCH;
			end
			ST_FETCH: state_d = ST_RUN;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + RAW'(1);
			// Hold the result beat until taken
			if (take) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/msws_dp.sv */
`timescale 1ns / 1ps

module msws_dp #(
	parameter int STRIPS         = 8,
	parameter int LEDS_PER_STRIP = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  msws_pkg::cmd_t cmd,
	output msws_pkg::sts_t sts,
	input  logic [((STRIPS * ((LEDS_PER_STRIP + 1) / 2) > 1) ?
		$clog2(STRIPS * ((LEDS_PER_STRIP + 1) / 2)) : 1)-1:0] clear_row,
	input  logic [1:0]     operation,
	input  logic [2:0]     strip,
	input  logic [5:0]     led_index,
	input  logic [7:0]     red,
	input  logic [7:0]     green,
	input  logic [7:0]     blue,
	input  logic [7:0]     color_code,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [15:0]    cfg_data,
	output logic [7:0]     pin_levels,
	output logic           busy_res,
	output logic           accepted
);

	localparam int PAIRS = (LEDS_PER_STRIP + 1) / 2;
	localparam int ROWS  = STRIPS * PAIRS;
	localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PAW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	// Byte slot of the last byte in the last pair row
	localparam logic [2:0] LAST_BIP = (LEDS_PER_STRIP % 2 == 0) ? 3'd5 : 3'd2;

	// Configuration registers
	logic [11:0] one_high_q, one_low_q, zero_high_q, zero_low_q;
	logic [15:0] latch_gap_q;
	logic [6:0]  intensity_q;

	// Frame store: one row per LED pair, G R B of the even LED in the upper half
	logic [47:0] mem [ROWS];
	logic [47:0] rd_q;

	// Serializer state
	logic [1:0]     phase_q;
	logic [15:0]    cnt_q;
	logic [2:0]     bit_q;
	logic [2:0]     bip_q;
	logic [PAW-1:0] pair_q;
	logic [2:0]     strip_q;
	logic [7:0]     byte_q;

	// Result register
	logic [7:0] pin_q;
	logic       busy_q;
	logic       acc_q;

	logic [1:0]     nx_phase;
	logic [15:0]    nx_cnt;
	logic [2:0]     nx_bit;
	logic [2:0]     nx_bip;
	logic [PAW-1:0] nx_pair;
	logic [2:0]     nx_strip;
	logic           acc;
	logic           fetch;
	logic           we_hi, we_lo;
	logic [PAW-1:0] wr_pair;
	logic [47:0]    wr_data;
	logic [RAW-1:0] wr_row, rd_row;
	logic           busy, strip_ok, rgb_ok, code_ok;
	logic           last_byte;
	msws_pkg::color_t col;
	logic [7:0]     sel_byte;

	assign busy      = (phase_q != msws_pkg::PH_IDLE);
	assign strip_ok  = ({1'b0, strip} < 4'(STRIPS));
	assign rgb_ok    = !busy && strip_ok && ({1'b0, led_index} < 7'(LEDS_PER_STRIP));
	assign code_ok   = !busy && strip_ok && ({1'b0, led_index} < 7'(PAIRS));
	assign last_byte = (pair_q == PAW'(PAIRS - 1)) && (bip_q == LAST_BIP);
	assign col       = msws_pkg::code_color(color_code, intensity_q);

	// Decode the item and work out the state after it
	always_comb begin
		nx_phase = phase_q;
		nx_cnt   = cnt_q;
		nx_bit   = bit_q;
		nx_bip   = bip_q;
		nx_pair  = pair_q;
		nx_strip = strip_q;
		acc      = 1'b0;
		fetch    = 1'b0;
		we_hi    = 1'b0;
		we_lo    = 1'b0;
		wr_pair  = led_index[PAW-1:0];
		wr_data  = {green, red, blue, green, red, blue};
		case (operation)
			msws_pkg::OP_RGB: begin
				wr_pair = led_index[PAW:1];
				if (rgb_ok) begin
					acc   = 1'b1;
					we_hi = !led_index[0];
					we_lo = led_index[0];
				end
			end
			msws_pkg::OP_CODE: begin
				wr_data = {col.g, col.r, col.b, col.g, col.r, col.b};
				if (code_ok) begin
					acc   = 1'b1;
					we_hi = 1'b1;
					we_lo = ({led_index, 1'b1} < 7'(LEDS_PER_STRIP));
				end
			end
			msws_pkg::OP_REFRESH: begin
				if (!busy && strip_ok) begin
					acc      = 1'b1;
					fetch    = 1'b1;
					nx_strip = strip;
					nx_bit   = 3'd0;
					nx_bip   = 3'd0;
					nx_pair  = '0;
					nx_phase = msws_pkg::PH_HIGH;
				end
			end
			msws_pkg::OP_TICK: begin
				if (busy) begin
					if (cnt_q > 16'd1) begin
						nx_cnt = cnt_q - 16'd1;
					end else begin
						case (phase_q)
							msws_pkg::PH_HIGH: begin
								nx_phase = msws_pkg::PH_LOW;
								nx_cnt   = byte_q[3'd7 - bit_q] ?
									{4'd0, one_low_q} : {4'd0, zero_low_q};
							end
							msws_pkg::PH_LOW: begin
								if (bit_q != 3'd7) begin
									nx_bit   = bit_q + 3'd1;
									nx_phase = msws_pkg::PH_HIGH;
									nx_cnt   = byte_q[3'd6 - bit_q] ?
										{4'd0, one_high_q} : {4'd0, zero_high_q};
								end else if (!last_byte) begin
									// Next byte comes from the store; count loads after the read
									nx_bit   = 3'd0;
									nx_phase = msws_pkg::PH_HIGH;
									fetch    = 1'b1;
									if (bip_q == 3'd5) begin
										nx_bip  = 3'd0;
										nx_pair = pair_q + PAW'(1);
									end else begin
										nx_bip = bip_q + 3'd1;
									end
								end else begin
									nx_phase = msws_pkg::PH_LATCH;
									nx_cnt   = latch_gap_q;
								end
							end
							default: begin
								nx_phase = msws_pkg::PH_IDLE;
								nx_cnt   = 16'd0;
								nx_bit   = 3'd0;
								nx_bip   = 3'd0;
								nx_pair  = '0;
							end
						endcase
					end
				end
			end
			default: acc = 1'b0;
		endcase
	end

	assign sts.fetch = fetch;
	assign wr_row = RAW'(strip) * RAW'(PAIRS) + RAW'(wr_pair);
	assign rd_row = RAW'(nx_strip) * RAW'(PAIRS) + RAW'(nx_pair);

	// Pick the byte slot out of the fetched pair row
	always_comb begin
		case (bip_q)
			3'd0:    sel_byte = rd_q[47:40];
			3'd1:    sel_byte = rd_q[39:32];
			3'd2:    sel_byte = rd_q[31:24];
			3'd3:    sel_byte = rd_q[23:16];
			3'd4:    sel_byte = rd_q[15:8];
			3'd5:    sel_byte = rd_q[7:0];
			default: sel_byte = 8'd0;
		endcase
	end

	// Frame store: sweep clear after reset, pixel writes, registered read
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			mem[clear_row] <= '0;
		end else if (cmd.take) begin
			if (we_hi) mem[wr_row][47:24] <= wr_data[47:24];
			if (we_lo) mem[wr_row][23:0]  <= wr_data[23:0];
		end
		rd_q <= mem[rd_row];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_high_q  <= msws_pkg::RST_ONE_HIGH;
			one_low_q   <= msws_pkg::RST_ONE_LOW;
			zero_high_q <= msws_pkg::RST_ZERO_HIGH;
			zero_low_q  <= msws_pkg::RST_ZERO_LOW;
			latch_gap_q <= msws_pkg::RST_LATCH_GAP;
			intensity_q <= msws_pkg::RST_INTENSITY;
		end else if (cfg_we) begin
			case (cfg_index)
				msws_pkg::REG_ONE_HIGH:  one_high_q  <= cfg_data[11:0];
				msws_pkg::REG_ONE_LOW:   one_low_q   <= cfg_data[11:0];
				msws_pkg::REG_ZERO_HIGH: zero_high_q <= cfg_data[11:0];
				msws_pkg::REG_ZERO_LOW:  zero_low_q  <= cfg_data[11:0];
				msws_pkg::REG_LATCH_GAP: latch_gap_q <= cfg_data;
				msws_pkg::REG_INTENSITY: intensity_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Advance serializer state; load byte and high count after a fetch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= msws_pkg::PH_IDLE;
			cnt_q   <= '0;
			bit_q   <= '0;
			bip_q   <= '0;
			pair_q  <= '0;
			strip_q <= '0;
			byte_q  <= '0;
		end else if (cmd.take) begin
			phase_q <= nx_phase;
			cnt_q   <= nx_cnt;
			bit_q   <= nx_bit;
			bip_q   <= nx_bip;
			pair_q  <= nx_pair;
			strip_q <= nx_strip;
		end else if (cmd.load) begin
			byte_q <= sel_byte;
			cnt_q  <= sel_byte[7] ? {4'd0, one_high_q} : {4'd0, zero_high_q};
		end
	end

	// Capture the result beat
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pin_q  <= (nx_phase == msws_pkg::PH_HIGH) ? (8'd1 << nx_strip) : 8'd0;
			busy_q <= (nx_phase != msws_pkg::PH_IDLE);
			acc_q  <= acc;
		end
	end

	assign pin_levels = pin_q;
	assign busy_res   = busy_q;
	assign accepted   = acc_q;

endmodule

/* rtl/msws_checker.sv */
`timescale 1ns / 1ps

module msws_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_ready,
	input logic [1:0] item_operation,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] result_pin_levels,
	input logic       result_busy_res,
	input logic       result_accepted
);

	// At most one strip line is driven
	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0(result_pin_levels))
		else $error("more than one strip line high");

	// A driven line means a refresh is in progress
	a_line_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_pin_levels != 8'd0) |-> result_busy_res)
		else $error("line high while not busy");

	// Every taken item yields a result beat on the next cycle
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> result_valid)
		else $error("taken item produced no result");

	// A tick is never reported as accepted
	a_tick_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item_operation == msws_pkg::OP_TICK)
		|=> !result_accepted)
		else $error("tick reported as accepted");

	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=>
		(result_valid && $stable(result_pin_levels) && $stable(result_accepted)))
		else $error("stalled result changed");

endmodule

bind multi_strip_ws2812_serializer_core msws_checker u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.item_operation    (item.operation),
	.result_valid      (result.valid),
	.result_ready      (result.ready),
	.result_pin_levels (result.pin_levels),
	.result_busy_res   (result.busy_res),
	.result_accepted   (result.accepted)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;

	localparam int STRIPS        = 8;
	localparam int LEDS          = 4;
	localparam int STRIP_BYTES   = LEDS * 3;
	localparam int STORE_BYTES   = STRIPS * STRIP_BYTES;
	localparam int RANDOM_ITEMS  = 450;
	localparam int PHASE_ITEMS   = 150;
	localparam int HOLD_CYCLES   = 300;

	// Letters and register indexes the package leaves out
	localparam logic [7:0] CODE_N      = 8'h6E;
	localparam logic [2:0] REG_SPARE_6 = 3'd6;
	localparam logic [2:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] strip;
		logic [5:0] led;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] code;
	} item_t;

	typedef struct packed {
		logic [7:0] pins;
		logic       busy;
		logic       acc;
	} beat_t;

	// Frame store, bit timer and line levels as the block should see them
	class led_line_scoreboard;
		logic [7:0]  frame_bytes [STORE_BYTES];
		logic [2:0]  act_strip;
		int          byte_pos;
		int          bit_pos;
		logic [1:0]  line_phase;
		int          ticks_left;
		int          one_hi;
		int          one_lo;
		int          zero_hi;
		int          zero_lo;
		int          latch_gap;
		int          level;
		beat_t       due_beats [$];
		int          errors;

		function new();
			foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
			act_strip  = '0;
			byte_pos   = 0;
			bit_pos    = 0;
			line_phase = msws_pkg::PH_IDLE;
			ticks_left = 0;
			one_hi     = msws_pkg::RST_ONE_HIGH;
			one_lo     = msws_pkg::RST_ONE_LOW;
			zero_hi    = msws_pkg::RST_ZERO_HIGH;
			zero_lo    = msws_pkg::RST_ZERO_LOW;
			latch_gap  = msws_pkg::RST_LATCH_GAP;
			level      = msws_pkg::RST_INTENSITY;
			errors     = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				msws_pkg::REG_ONE_HIGH:  one_hi = data[11:0];
				msws_pkg::REG_ONE_LOW:   one_lo = data[11:0];
				msws_pkg::REG_ZERO_HIGH: zero_hi = data[11:0];
				msws_pkg::REG_ZERO_LOW:  zero_lo = data[11:0];
				msws_pkg::REG_LATCH_GAP: latch_gap = data;
				msws_pkg::REG_INTENSITY: level = data[6:0];
				default: ;
			endcase
		endfunction

		function bit line_busy();
			return line_phase != msws_pkg::PH_IDLE;
		endfunction

		function int pending();
			return due_beats.size();
		endfunction

		function logic [7:0] clip(int v);
			return (v > 255) ? 8'hFF : 8'(v);
		endfunction

		function void put_led(int s, int led, logic [7:0] r, logic [7:0] g, logic [7:0] b);
			int base;
			if (s >= STRIPS || led >= LEDS) return;
			base = s * STRIP_BYTES + led * 3;
			frame_bytes[base]     = g;
			frame_bytes[base + 1] = r;
			frame_bytes[base + 2] = b;
		endfunction

		function void scaled_color(logic [7:0] code, output logic [7:0] r, g, b);
			int rv, gv, bv;
			rv = 0;
			gv = 0;
			bv = 0;
			case (code)
				msws_pkg::CODE_V: gv = level;
				msws_pkg::CODE_R: rv = level;
				msws_pkg::CODE_L: bv = level;
				msws_pkg::CODE_J: begin
					rv = level;
					gv = level;
				end
				msws_pkg::CODE_M: begin
					rv = level;
					bv = level;
				end
				msws_pkg::CODE_T: begin
					gv = 2 * level;
					bv = level;
				end
				msws_pkg::CODE_O: begin
					rv = (5 * level) / 2;
					gv = level / 2;
				end
				msws_pkg::CODE_B: begin
					rv = level;
					gv = level;
					bv = level;
				end
				default: ;
			endcase
			r = clip(rv);
			g = clip(gv);
			b = clip(bv);
		endfunction

		function bit bit_now();
			int idx;
			idx = int'(act_strip) * STRIP_BYTES + byte_pos;
			if (idx >= STORE_BYTES) return 1'b0;
			return frame_bytes[idx][7 - bit_pos];
		endfunction

		function void start_high();
			line_phase = msws_pkg::PH_HIGH;
			ticks_left = bit_now() ? one_hi : zero_hi;
		endfunction

		// One tick of the bit timer
		function void step_timer();
			if (line_phase == msws_pkg::PH_IDLE) return;
			if (ticks_left > 1) begin
				ticks_left--;
				return;
			end
			case (line_phase)
				msws_pkg::PH_HIGH: begin
					line_phase = msws_pkg::PH_LOW;
					ticks_left = bit_now() ? one_lo : zero_lo;
				end
				msws_pkg::PH_LOW: begin
					if (bit_pos < 7) begin
						bit_pos++;
						start_high();
					end else if (byte_pos + 1 < STRIP_BYTES) begin
						bit_pos = 0;
						byte_pos++;
						start_high();
					end else begin
						line_phase = msws_pkg::PH_LATCH;
						ticks_left = latch_gap;
					end
				end
				default: begin
					line_phase = msws_pkg::PH_IDLE;
					ticks_left = 0;
					byte_pos   = 0;
					bit_pos    = 0;
				end
			endcase
		endfunction

		// Apply one accepted item and queue the beat it should produce
		function void note_item(item_t it);
			beat_t      exp;
			bit         was_busy;
			int         led2;
			logic [7:0] cr, cg, cb;
			was_busy = line_busy();
			exp.acc  = 1'b0;
			case (it.op)
				msws_pkg::OP_RGB: begin
					if (!was_busy && int'(it.strip) < STRIPS && int'(it.led) < LEDS) begin
						put_led(it.strip, it.led, it.r, it.g, it.b);
						exp.acc = 1'b1;
					end
				end
				msws_pkg::OP_CODE: begin
					led2 = 2 * int'(it.led);
					if (!was_busy && int'(it.strip) < STRIPS && led2 < LEDS) begin
						scaled_color(it.code, cr, cg, cb);
						put_led(it.strip, led2, cr, cg, cb);
						put_led(it.strip, led2 + 1, cr, cg, cb);
						exp.acc = 1'b1;
					end
				end
				msws_pkg::OP_REFRESH: begin
					if (!was_busy && int'(it.strip) < STRIPS) begin
						act_strip = it.strip;
						byte_pos  = 0;
						bit_pos   = 0;
						start_high();
						exp.acc = 1'b1;
					end
				end
				default: step_timer();
			endcase
			exp.pins = (line_phase == msws_pkg::PH_HIGH) ? 8'(1 << act_strip) : 8'h00;
			exp.busy = line_busy();
			due_beats.push_back(exp);
		endfunction

		function void check_beat(beat_t got);
			beat_t exp;
			if (due_beats.size() == 0) begin
				$error("result beat with no item waiting: pin_levels %0h busy_res %0b accepted %0b",
					got.pins, got.busy, got.acc);
				errors++;
				return;
			end
			exp = due_beats.pop_front();
			if (got.pins !== exp.pins) begin
				$error("pin_levels expected %0h actual %0h", exp.pins, got.pins);
				errors++;
			end
			if (got.busy !== exp.busy) begin
				$error("busy_res expected %0b actual %0b", exp.busy, got.busy);
				errors++;
			end
			if (got.acc !== exp.acc) begin
				$error("accepted expected %0b actual %0b", exp.acc, got.acc);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	msws_item_if   item_ch ();
	msws_result_if res_ch ();
	msws_cfg_if    cfg_ch ();

	multi_strip_ws2812_serializer_core #(
		.STRIPS         (STRIPS),
		.LEDS_PER_STRIP (LEDS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	led_line_scoreboard sb = new();

	int gap_pct   = 0;
	int stall_pct = 0;
	bit hold_req  = 1'b0;
	int items_sent = 0;

	logic [7:0] letters [10] = '{msws_pkg::CODE_V, msws_pkg::CODE_R, msws_pkg::CODE_L,
		msws_pkg::CODE_J, msws_pkg::CODE_M, msws_pkg::CODE_T, msws_pkg::CODE_O,
		msws_pkg::CODE_B, CODE_N, 8'h41};

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Result side: random stalls, calm stretches and one long hold on request
	initial begin
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Sample each result beat at the edge, compare once the edge has settled
	always begin
		beat_t got;
		@(posedge clk);
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.pins = res_ch.pin_levels;
			got.busy = res_ch.busy_res;
			got.acc  = res_ch.accepted;
			#1;
			sb.check_beat(got);
		end
	end

	function automatic item_t make_item(logic [1:0] op, logic [2:0] s, logic [5:0] led,
		logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] code);
		item_t it;
		it.op    = op;
		it.strip = s;
		it.led   = led;
		it.r     = r;
		it.g     = g;
		it.b     = b;
		it.code  = code;
		return it;
	endfunction

	function automatic item_t rand_item(logic [1:0] op);
		return make_item(op, 3'($urandom), 6'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
	endfunction

	// Mostly in-range pixel and letter writes, sometimes any index or code
	function automatic item_t rand_write();
		item_t it;
		it = rand_item($urandom_range(0, 1) ? msws_pkg::OP_CODE : msws_pkg::OP_RGB);
		if ($urandom_range(0, 99) < 80)
			it.led = (it.op == msws_pkg::OP_CODE) ? 6'($urandom_range(0, 1)) :
				6'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 70)
			it.code = letters[$urandom_range(0, 9)];
		return it;
	endfunction

	task automatic send_item(input item_t it);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.operation  <= it.op;
		item_ch.strip      <= it.strip;
		item_ch.led_index  <= it.led;
		item_ch.red        <= it.r;
		item_ch.green      <= it.g;
		item_ch.blue       <= it.b;
		item_ch.color_code <= it.code;
		@(posedge clk);
		while (item_ch.ready !== 1'b1) @(posedge clk);
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic wait_results();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.data      <= data;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1) @(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Load all timing registers and the brightness; junk lands in unused upper bits
	task automatic configure(input int oh, input int ol, input int zh, input int zl,
		input int lg, input int lvl);
		write_reg(msws_pkg::REG_ONE_HIGH, {4'($urandom), 12'(oh)});
		write_reg(msws_pkg::REG_ONE_LOW, {4'($urandom), 12'(ol)});
		write_reg(msws_pkg::REG_ZERO_HIGH, {4'($urandom), 12'(zh)});
		write_reg(msws_pkg::REG_ZERO_LOW, {4'($urandom), 12'(zl)});
		write_reg(msws_pkg::REG_LATCH_GAP, 16'(lg));
		write_reg(msws_pkg::REG_INTENSITY, {9'($urandom), 7'(lvl)});
		write_reg(REG_SPARE_6, 16'($urandom));
		write_reg(REG_SPARE_7, 16'($urandom));
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Tick the line back to idle, mixing in items that must be rejected
	task automatic drain_line(input int noise_pct);
		while (sb.line_busy()) begin
			if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct)
				send_item(rand_item(2'($urandom_range(0, 3))));
			else
				send_item(rand_item(msws_pkg::OP_TICK));
		end
	endtask

	task automatic settle();
		drain_line(0);
		wait_results();
		repeat (4) @(posedge clk);
	endtask

	task automatic run_sequence(input int n);
		repeat ($urandom_range(1, 6)) send_item(rand_write());
		if (n < 2 || $urandom_range(0, 99) < 85) begin
			send_item(rand_item(msws_pkg::OP_REFRESH));
			if (n == 0) hold_req = 1'b1;
			if (n == 1) begin
				repeat (10) send_item(rand_item(msws_pkg::OP_TICK));
				wait_results();
			end
			drain_line(8);
		end else begin
			repeat ($urandom_range(1, 4)) send_item(rand_item(2'($urandom_range(0, 3))));
		end
	endtask

	initial begin
		int start_count;
		int phase_start;
		int phase_no;
		int seq_no;
		item_t it;

		arst_n             <= 1'b0;
		item_ch.valid      <= 1'b0;
		item_ch.operation  <= msws_pkg::OP_TICK;
		item_ch.strip      <= '0;
		item_ch.led_index  <= '0;
		item_ch.red        <= '0;
		item_ch.green      <= '0;
		item_ch.blue       <= '0;
		item_ch.color_code <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.reg_index   <= '0;
		cfg_ch.data        <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed writes under the reset register values
		gap_pct   = 25;
		stall_pct = 25;
		send_item(make_item(msws_pkg::OP_TICK, 3'd0, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(make_item(msws_pkg::OP_RGB, 3'd0, 6'd0, 8'hFF, 8'h00, 8'hFF, 8'h00));
		send_item(make_item(msws_pkg::OP_RGB, 3'd7, 6'd3, 8'h00, 8'hFF, 8'h00, 8'hFF));
		send_item(make_item(msws_pkg::OP_RGB, 3'd3, 6'd4, 8'h12, 8'h34, 8'h56, 8'h00));
		send_item(make_item(msws_pkg::OP_RGB, 3'd3, 6'd63, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(make_item(msws_pkg::OP_CODE, 3'd1, 6'd0, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_V));
		send_item(make_item(msws_pkg::OP_CODE, 3'd1, 6'd1, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_R));
		send_item(make_item(msws_pkg::OP_CODE, 3'd2, 6'd0, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_L));
		send_item(make_item(msws_pkg::OP_CODE, 3'd2, 6'd1, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_J));
		send_item(make_item(msws_pkg::OP_CODE, 3'd3, 6'd0, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_M));
		send_item(make_item(msws_pkg::OP_CODE, 3'd3, 6'd1, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_T));
		send_item(make_item(msws_pkg::OP_CODE, 3'd4, 6'd0, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_O));
		send_item(make_item(msws_pkg::OP_CODE, 3'd4, 6'd1, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_B));
		send_item(make_item(msws_pkg::OP_CODE, 3'd5, 6'd0, 8'h00, 8'h00, 8'h00, CODE_N));
		send_item(make_item(msws_pkg::OP_CODE, 3'd5, 6'd1, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(make_item(msws_pkg::OP_CODE, 3'd6, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(make_item(msws_pkg::OP_CODE, 3'd6, 6'd2, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_B));
		send_item(make_item(msws_pkg::OP_CODE, 3'd6, 6'd63, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_B));
		// Shorten the bit times before the first refresh
		wait_results();
		configure(1, 1, 1, 1, 1, 10);
		send_item(make_item(msws_pkg::OP_REFRESH, 3'd0, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
		// Writes and a refresh while the line is busy
		send_item(make_item(msws_pkg::OP_RGB, 3'd0, 6'd1, 8'hAA, 8'h55, 8'hAA, 8'h00));
		send_item(make_item(msws_pkg::OP_CODE, 3'd0, 6'd0, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_B));
		send_item(make_item(msws_pkg::OP_REFRESH, 3'd7, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
		settle();

		// Random phases, each under its own register setting
		start_count = items_sent;
		phase_no    = 0;
		seq_no      = 0;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			case (phase_no)
				0: configure(0, 0, 0, 0, 0, 127);
				1: configure(2, 1, 1, 2, 3, $urandom_range(0, 102));
				default: configure($urandom_range(1, 4), $urandom_range(1, 4),
					$urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 40),
					$urandom_range(0, 127));
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : 25;
				stall_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
				run_sequence(seq_no);
				seq_no++;
			end
			settle();
			phase_no++;
		end

		// Saturated letters at full brightness on a short line, no idling on either side
		gap_pct   = 0;
		stall_pct = 0;
		configure(1, 2, 1, 1, 2, 127);
		send_item(make_item(msws_pkg::OP_RGB, 3'd7, 6'd0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
		send_item(make_item(msws_pkg::OP_RGB, 3'd7, 6'd1, 8'hFF, 8'hFF, 8'hFF, 8'h00));
		send_item(make_item(msws_pkg::OP_RGB, 3'd7, 6'd2, 8'hFF, 8'hFF, 8'hFF, 8'h00));
		send_item(make_item(msws_pkg::OP_RGB, 3'd7, 6'd3, 8'hFF, 8'hFF, 8'hFE, 8'h00));
		send_item(make_item(msws_pkg::OP_CODE, 3'd5, 6'd0, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_O));
		send_item(make_item(msws_pkg::OP_CODE, 3'd5, 6'd1, 8'h00, 8'h00, 8'h00,
			msws_pkg::CODE_T));
		send_item(make_item(msws_pkg::OP_REFRESH, 3'd5, 6'd0, 8'h00, 8'h00, 8'h00, 8'h00));
		drain_line(0);
		wait_results();
		repeat (20) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// Watchdog
	initial begin
		#(600_000);
		$display("testbench failed");
		$finish;
	end

endmodule

/* multi_strip_ws2812_serializer_core.f */
rtl/msws_pkg.sv
rtl/msws_item_if.sv
rtl/msws_result_if.sv
rtl/msws_cfg_if.sv
rtl/msws_ctrl.sv
rtl/msws_dp.sv
rtl/multi_strip_ws2812_serializer_core.sv
rtl/msws_checker.sv
bench/testbench.sv
